// ===== rtl/fftw_pkg.sv =====
// fftw_pkg: shared constants, state type and helper functions of the twiddle generator
// used by fft_twiddle_table_generator_top; depends on nothing else
`default_nettype none

package fftw_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int MAX_PASSES = 7;
  localparam int LEN_W      = $clog2(TABLE_SIZE) + 1;
  localparam int FRAC_W     = 20;
  localparam int STAGES     = 16;
  localparam int XY_W       = 34;

  localparam logic [2:0] REG_PASS_COUNT = 3'd0;
  localparam logic [2:0] REG_RADIX_1    = 3'd1;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIV,
    ST_ROT,
    ST_EMIT
  } gen_state_t;

  function automatic logic [4:0] eff_radix(input logic [4:0] v);
    if (v < 5'd2) return 5'd2;
    if (v > 5'd16) return 5'd16;
    return v;
  endfunction

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] a;
    unique case (i)
      4'd0:  a = 32'd536870912;
      4'd1:  a = 32'd316933406;
      4'd2:  a = 32'd167458907;
      4'd3:  a = 32'd85004756;
      4'd4:  a = 32'd42667331;
      4'd5:  a = 32'd21354465;
      4'd6:  a = 32'd10679838;
      4'd7:  a = 32'd5340245;
      4'd8:  a = 32'd2670163;
      4'd9:  a = 32'd1335087;
      4'd10: a = 32'd667544;
      4'd11: a = 32'd333772;
      4'd12: a = 32'd166886;
      4'd13: a = 32'd83443;
      4'd14: a = 32'd41722;
      4'd15: a = 32'd20861;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // round to nearest, then saturate to q1.15
  function automatic logic [15:0] to_q15(input logic signed [XY_W:0] v);
    logic signed [XY_W:0] r;
    r = (v + 35'sd16384) >>> 15;
    if (r > 35'sd32767) return 16'h7fff;
    if (r < -35'sd32768) return 16'h8000;
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fft_twiddle_table_generator_top.sv =====
// fft_twiddle_table_generator_top: mixed-radix fft twiddle table, one entry per request beat
// depends on fftw_pkg
//
// usage: each beat on the request channel (req_valid/req_stall, field restart)
// produces one beat on the result channel (res_valid/res_stall). restart=1 goes
// back to the first entry and emits it. radices and pass count sit in an apb
// register file (index i at byte address 4*i); the user must write them only while
// idle, and the block itself does not enforce this. per beat: radix product
// accumulation over the passes in use (1 to 7), then for a real entry restoring
// division to 20 quotient bits (one quotient bit a cycle) and cordic rotation (one
// stage a cycle), then the result is loaded into the result register. a new request
// is taken only once the previous entry has been loaded. done or overflow beats skip
// the division and the rotation. the next request is taken while a result still
// waits; work then holds in the last step until the result register frees up.
// reset restores the default radices and returns to the first entry.
`default_nettype none

module fft_twiddle_table_generator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        restart,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [11:0]      entry_index,
  output logic signed [15:0] cos_value,
  output logic signed [15:0] sin_value,
  output logic [2:0]       pass_number,
  output logic             last,
  output logic             done_res,
  output logic             overflow
);
  import fftw_pkg::*;

  logic [2:0] pass_count;
  logic [4:0] radix [MAX_PASSES];

  gen_state_t state, state_next;

  logic [2:0]       pass_index;
  logic [11:0]      outer_counter;
  logic [4:0]       inner_counter;
  logic [LEN_W-1:0] entry_counter;
  logic             finished;

  logic [4:0]       step;
  logic [LEN_W-1:0] prod;
  logic             sat;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] groups;
  logic [4:0]       rad;
  logic             is_done;
  logic             is_ovf;
  logic [LEN_W-1:0] rem;
  logic [FRAC_W-1:0] quo;
  logic signed [XY_W-1:0] x, y;
  logic signed [31:0] z;

  logic [2:0]  pc_eff;
  logic [4:0]  r_i;
  logic [LEN_W+4:0] mul;
  logic        sat_now;
  logic        prod_last;
  logic        slot_free;
  logic [LEN_W:0] rem2;

  assign pready = 1'b1;

  always_comb begin
    pc_eff = (pass_count == 3'd0) ? 3'd1 : pass_count;
    r_i = eff_radix(radix[step[2:0]]);
    mul = prod * r_i;
    sat_now = sat || (mul > (LEN_W+5)'(TABLE_SIZE));
    prod_last = (step[2:0] == pc_eff - 3'd1);
    slot_free = !res_valid || !res_stall;
    rem2 = {rem, 1'b0};
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= 3'd3;
      radix[0] <= 5'd16;
      radix[1] <= 5'd16;
      radix[2] <= 5'd16;
      for (int i = 3; i < MAX_PASSES; i++) radix[i] <= 5'd2;
    end else if (psel && penable && pwrite) begin
      if (paddr[4:2] == REG_PASS_COUNT) pass_count <= pwdata[2:0];
      else radix[paddr[4:2] - REG_RADIX_1] <= pwdata[4:0];
    end
  end

  always_comb begin
    if (paddr[4:2] == REG_PASS_COUNT) prdata = {29'd0, pass_count};
    else prdata = {27'd0, radix[paddr[4:2] - REG_RADIX_1]};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid) state_next = ST_PROD;
      ST_PROD: begin
        if (prod_last) begin
          if (sat_now || finished || pass_index >= pc_eff) state_next = ST_EMIT;
          else state_next = ST_DIV;
        end
      end
      ST_DIV:  if (step == 5'(FRAC_W - 1)) state_next = ST_ROT;
      ST_ROT:  if (step[3:0] == 4'(STAGES - 1)) state_next = ST_EMIT;
      ST_EMIT: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic signed [XY_W:0] c_full, s_full;
  logic [4:0]  j_next;
  logic [11:0] k_next;
  logic [2:0]  p_next;
  logic        fin_next;

  always_comb begin
    unique case (quo[FRAC_W-1 -: 2])
      2'd0: begin c_full = x;  s_full = y;  end
      2'd1: begin c_full = -y; s_full = x;  end
      2'd2: begin c_full = -x; s_full = -y; end
      default: begin c_full = y; s_full = -x; end
    endcase
    j_next = inner_counter + 5'd1;
    k_next = outer_counter;
    p_next = pass_index;
    fin_next = finished;
    if (j_next >= rad) begin
      j_next = 5'd1;
      k_next = outer_counter + 12'd1;
      if ({1'b0, k_next} >= groups) begin
        k_next = 12'd0;
        p_next = pass_index + 3'd1;
        if (p_next >= pc_eff) fin_next = 1'b1;
      end
    end
  end

  // datapath and sequence counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_index <= 3'd0;
      outer_counter <= 12'd0;
      inner_counter <= 5'd1;
      entry_counter <= '0;
      finished <= 1'b0;
      res_valid <= 1'b0;
      step <= '0;
    end else begin
      if (res_valid && !res_stall && state != ST_EMIT) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          prod <= LEN_W'(1);
          sat <= 1'b0;
          groups <= LEN_W'(1);
          len <= LEN_W'(1);
          rad <= 5'd2;
          if (req_valid && restart) begin
            pass_index <= 3'd0;
            outer_counter <= 12'd0;
            inner_counter <= 5'd1;
            entry_counter <= '0;
            finished <= 1'b0;
          end
        end
        ST_PROD: begin
          sat <= sat_now;
          prod <= mul[LEN_W-1:0];
          if (step[2:0] == pass_index) begin
            groups <= prod;
            len <= mul[LEN_W-1:0];
            rad <= r_i;
          end
          if (prod_last) begin
            step <= '0;
            is_ovf <= sat_now;
            is_done <= sat_now || finished || pass_index >= pc_eff;
            if (!sat_now && pass_index >= pc_eff) finished <= 1'b1;
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_DIV: begin
          if (step == 5'd0) begin
            logic [4:0]  jc;
            logic [11:0] kc;
            logic [16:0] m;
            jc = (inner_counter < 5'd1) ? 5'd1 : inner_counter;
            if (jc >= rad) jc = rad - 5'd1;
            kc = ({1'b0, outer_counter} >= groups) ? 12'(groups - LEN_W'(1)) : outer_counter;
            inner_counter <= jc;
            outer_counter <= kc;
            m = jc * kc;
            // phase below len, so the modulo drops out
            if ({m[LEN_W-1:0], 1'b0} >= {1'b0, len}) begin
              rem <= LEN_W'({m[LEN_W-1:0], 1'b0} - {1'b0, len});
              quo <= {quo[FRAC_W-2:0], 1'b1};
            end else begin
              rem <= {m[LEN_W-2:0], 1'b0};
              quo <= {quo[FRAC_W-2:0], 1'b0};
            end
          end else if (rem2 >= {1'b0, len}) begin
            rem <= LEN_W'(rem2 - {1'b0, len});
            quo <= {quo[FRAC_W-2:0], 1'b1};
          end else begin
            rem <= rem2[LEN_W-1:0];
            quo <= {quo[FRAC_W-2:0], 1'b0};
          end
          if (step == 5'(FRAC_W - 1)) begin
            step <= '0;
            x <= CORDIC_X0;
            y <= '0;
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_ROT: begin
          logic signed [31:0] z_cur;
          z_cur = (step == 5'd0) ? $signed({2'b00, quo[FRAC_W-3:0], 12'd0}) : z;
          if (!z_cur[31]) begin
            x <= x - (y >>> step[3:0]);
            y <= y + (x >>> step[3:0]);
            z <= z_cur - $signed(atan_turn(step[3:0]));
          end else begin
            x <= x + (y >>> step[3:0]);
            y <= y - (x >>> step[3:0]);
            z <= z_cur + $signed(atan_turn(step[3:0]));
          end
          step <= step + 5'd1;
        end
        ST_EMIT: begin
          if (slot_free) begin
            res_valid <= 1'b1;
            done_res <= is_done;
            overflow <= is_ovf;
            if (is_done) begin
              entry_index <= '0;
              cos_value <= '0;
              sin_value <= '0;
              pass_number <= '0;
              last <= 1'b0;
            end else begin
              entry_index <= entry_counter[11:0];
              cos_value <= to_q15(c_full);
              sin_value <= to_q15(-s_full);
              pass_number <= pass_index;
              last <= fin_next;
              inner_counter <= j_next;
              outer_counter <= k_next;
              pass_index <= p_next;
              finished <= fin_next;
              entry_counter <= entry_counter + LEN_W'(1);
            end
          end
        end
        default: step <= '0;
      endcase
    end
  end

  a_ovf_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && overflow |-> done_res)
    else $error("overflow beat without done flag");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> cos_value == 16'sd0 && sin_value == 16'sd0 && !last)
    else $error("done beat carries data");

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && slot_free |=> res_valid && state == ST_IDLE)
    else $error("result not loaded when slot was free");

endmodule

`default_nettype wire

// ===== tb/fft_twiddle_table_generator_top_tb.sv =====
// testbench for fft_twiddle_table_generator_top: drives request beats, some with restart, checks every result beat
// against an in-bench twiddle predictor; uses fftw_pkg for register indexes
`default_nettype none

module fft_twiddle_table_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fftw_pkg::*;

  typedef struct packed {
    logic [11:0] idx;
    logic [15:0] cosv;
    logic [15:0] sinv;
    logic [2:0]  pnum;
    logic        lst;
    logic        dn;
    logic        ovf;
  } twiddle_entry_t;

  localparam int WATCHDOG_CYCLES = 20000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic req_valid = 0, restart = 0, req_stall;
  logic res_valid, res_stall = 0;
  logic [11:0] entry_index;
  logic signed [15:0] cos_value, sin_value;
  logic [2:0] pass_number;
  logic last, done_res, overflow;

  always #5 clk = ~clk;

  fft_twiddle_table_generator_top i_dut (.*);

  // predictor state
  logic [2:0] cfg_passes;
  logic [4:0] cfg_radix [7];
  int unsigned gen_pass, gen_outer, gen_inner, gen_entry;
  bit gen_finished;

  twiddle_entry_t expected_entries[$];
  int errors = 0;
  int entries_sent = 0, entries_checked = 0, tables_done = 0, overflow_seen = 0;
  int idle_pct = 0, stall_pct = 0;
  bit hold_res = 0;
  int quiet_cycles = 0;

  function automatic int unsigned radix_of(int unsigned p);
    int unsigned v;
    v = cfg_radix[p % 7];
    if (v < 2) return 2;
    if (v > 16) return 16;
    return v;
  endfunction

  function automatic int unsigned passes_in_use();
    int unsigned pc;
    pc = cfg_passes;
    if (pc < 1) pc = 1;
    return pc;
  endfunction

  function automatic int unsigned length_through(int unsigned p);
    longint unsigned prod;
    prod = 1;
    for (int unsigned i = 0; i <= p && i < 7; i++) begin
      prod *= radix_of(i);
      if (prod > TABLE_SIZE) return TABLE_SIZE + 1;
    end
    return prod;
  endfunction

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] q15(longint v);
    longint r;
    r = asr(v + 16384, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void rotate(int unsigned m, int unsigned len,
                                 output logic [15:0] c_q, output logic [15:0] ns_q);
    longint unsigned turn_frac;
    logic [31:0] phase;
    longint x, y, z, dx, dy, c, s;
    turn_frac = (longint'(m) << 20) / len;
    phase = turn_frac[19:0] << 12;
    z = phase[29:0];
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_turn(i);
      end else begin
        x += dx; y -= dy; z += atan_turn(i);
      end
    end
    case (phase[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c_q = q15(c);
    ns_q = q15(-s);
  endfunction

  function automatic void rewind_table();
    gen_pass = 0; gen_outer = 0; gen_inner = 1; gen_entry = 0; gen_finished = 0;
  endfunction

  function automatic twiddle_entry_t next_twiddle(bit rs);
    twiddle_entry_t e;
    int unsigned pc, r, len, groups, j, k;
    e = '0;
    if (rs) rewind_table();
    pc = passes_in_use();
    if (length_through(pc - 1) > TABLE_SIZE) begin
      e.dn = 1; e.ovf = 1;
      return e;
    end
    if (gen_finished || gen_pass >= pc) begin
      gen_finished = 1; e.dn = 1;
      return e;
    end
    r = radix_of(gen_pass);
    len = length_through(gen_pass);
    groups = len / r;
    j = gen_inner;
    if (j < 1) j = 1;
    if (j >= r) j = r - 1;
    k = gen_outer;
    if (k >= groups) k = groups - 1;
    rotate((j * k) % len, len, e.cosv, e.sinv);
    e.idx = gen_entry[11:0];
    e.pnum = gen_pass[2:0];
    j++;
    if (j >= r) begin
      j = 1;
      k++;
      if (k >= groups) begin
        k = 0;
        gen_pass++;
        if (gen_pass >= pc) gen_finished = 1;
      end
    end
    gen_inner = j;
    gen_outer = k;
    gen_entry = (gen_entry + 1) & 13'h1fff;
    e.lst = gen_finished;
    return e;
  endfunction

  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {index, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (index == REG_PASS_COUNT) cfg_passes = value[2:0];
    else cfg_radix[index - REG_RADIX_1] = value[4:0];
  endtask

  task automatic send_beat(bit rs);
    @(posedge clk);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge clk);
    req_valid <= 1;
    restart <= rs;
    expected_entries = {expected_entries, next_twiddle(rs)};
    entries_sent++;
    do @(posedge clk); while (req_stall);
    req_valid <= 0;
  endtask

  task automatic drain();
    while (expected_entries.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // new radix set, then restart and walk the table with occasional restarts
  task automatic run_table(int unsigned pc, int unsigned r[7], int beats, int restart_pct);
    drain();
    write_reg(REG_PASS_COUNT, pc);
    for (int i = 0; i < 7; i++) write_reg(3'(REG_RADIX_1 + i), r[i]);
    send_beat(1);
    for (int i = 1; i < beats; i++) send_beat($urandom_range(99) < restart_pct);
  endtask

  task automatic test_reset_defaults();
    // default radices 16,16,16 give a 4096-entry table; walk its start
    for (int i = 0; i < 12; i++) send_beat(i == 5);
  endtask

  task automatic test_directed_corners();
    int unsigned r[7];
    r = '{2, 2, 2, 2, 2, 2, 2};
    run_table(0, r, 4, 0);              // zero passes acts as one, then exhaustion
    r = '{31, 0, 1, 17, 16, 2, 3};
    run_table(7, r, 3, 0);              // clamped radices, product over table size
    r = '{16, 16, 16, 2, 2, 2, 2};
    run_table(4, r, 2, 0);              // twice the table size: overflow
    r = '{16, 16, 16, 2, 2, 2, 2};
    run_table(3, r, 2, 0);              // exactly the table size
    r = '{2, 3, 2, 2, 2, 2, 2};
    run_table(2, r, 8, 0);              // finishes, then done beats, then restart
    send_beat(1);
  endtask

  task automatic test_mid_table_change();
    int unsigned r[7];
    r = '{5, 7, 3, 2, 2, 2, 2};
    run_table(3, r, 20, 0);
    drain();
    write_reg(REG_RADIX_1 + 3'd1, 2);   // shrink live radix, counters get clamped
    write_reg(REG_PASS_COUNT, 1);       // pass index now equals the count
    for (int i = 0; i < 3; i++) send_beat(0);
    drain();
    write_reg(REG_PASS_COUNT, 3);
    for (int i = 0; i < 3; i++) send_beat(0);
  endtask

  task automatic test_random_tables(int total);
    int unsigned r[7];
    int unsigned pc;
    int phase_no;
    phase_no = 0;
    while (total > 0) begin
      case (phase_no % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 74; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 74; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      pc = $urandom_range(7);
      for (int i = 0; i < 7; i++)
        r[i] = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16, 2);
      run_table(pc, r, 50, 4);
      total -= 50;
      phase_no++;
    end
    idle_pct = 0; stall_pct = 0;
  endtask

  task automatic test_backpressure();
    int unsigned r[7];
    r = '{4, 4, 2, 2, 2, 2, 2};
    drain();
    write_reg(REG_PASS_COUNT, 2);
    for (int i = 0; i < 7; i++) write_reg(3'(REG_RADIX_1 + i), r[i]);
    hold_res = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_res = 0;
      end
      for (int i = 0; i < 8; i++) send_beat(i == 0);
    join
  endtask

  // receiver stall
  always @(posedge clk)
    res_stall <= hold_res || (stall_pct > 0 && $urandom_range(99) < stall_pct);

  // result checker
  always @(posedge clk) begin
    twiddle_entry_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected_entries.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_entries.pop_front();
        entries_checked++;
        if (last) tables_done++;
        if (overflow) overflow_seen++;
        if (entry_index !== e.idx) begin
          $error("entry_index exp %0d got %0d", e.idx, entry_index); errors++;
        end
        if (cos_value !== e.cosv) begin
          $error("cos_value exp %0d got %0d", $signed(e.cosv), cos_value); errors++;
        end
        if (sin_value !== e.sinv) begin
          $error("sin_value exp %0d got %0d", $signed(e.sinv), sin_value); errors++;
        end
        if (pass_number !== e.pnum) begin
          $error("pass_number exp %0d got %0d", e.pnum, pass_number); errors++;
        end
        if (last !== e.lst) begin
          $error("last exp %0d got %0d", e.lst, last); errors++;
        end
        if (done_res !== e.dn) begin
          $error("done_res exp %0d got %0d", e.dn, done_res); errors++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, overflow); errors++;
        end
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall) || psel || rst)
      quiet_cycles <= 0;
    else if (expected_entries.size() > 0 || req_valid)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout waiting for a beat");
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cfg_passes = 3;
    cfg_radix = '{16, 16, 16, 2, 2, 2, 2};
    rewind_table();
    repeat (10) @(posedge clk);
    rst <= 0;
    test_reset_defaults();
    test_directed_corners();
    test_mid_table_change();
    test_backpressure();
    test_random_tables(800);
    drain();
    $display("covered %0d request beats, %0d results checked, %0d table ends, %0d overflow",
             entries_sent, entries_checked, tables_done, overflow_seen);
    $display("under idle, stall, mixed and long hold-off traffic, radices 2..16 and clamps");
    if (errors == 0 && expected_entries.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
